FILE: rtl/x86a_pkg.sv
// Package for the 8086 ALU: operation codes, flag positions, the pipeline record
// and small helper functions. It depends on nothing else.
package x86a_pkg;

    localparam logic [4:0] FN_INC  = 5'd0;
    localparam logic [4:0] FN_DEC  = 5'd1;
    localparam logic [4:0] FN_ADD  = 5'd2;
    localparam logic [4:0] FN_SUB  = 5'd3;
    localparam logic [4:0] FN_AND  = 5'd4;
    localparam logic [4:0] FN_OR   = 5'd5;
    localparam logic [4:0] FN_XOR  = 5'd6;
    localparam logic [4:0] FN_SHL  = 5'd7;
    localparam logic [4:0] FN_SHR  = 5'd8;
    localparam logic [4:0] FN_SAR  = 5'd9;
    localparam logic [4:0] FN_NEG  = 5'd10;
    localparam logic [4:0] FN_ROL  = 5'd11;
    localparam logic [4:0] FN_ROR  = 5'd12;
    localparam logic [4:0] FN_RCL  = 5'd13;
    localparam logic [4:0] FN_RCR  = 5'd14;
    localparam logic [4:0] FN_MUL  = 5'd15;
    localparam logic [4:0] FN_IMUL = 5'd16;
    localparam logic [4:0] FN_DIV  = 5'd17;
    localparam logic [4:0] FN_IDIV = 5'd18;

    localparam int F_CF = 0;
    localparam int F_PF = 2;
    localparam int F_AF = 4;
    localparam int F_ZF = 6;
    localparam int F_SF = 7;
    localparam int F_OF = 11;

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = 16 / DIV_STEPS_PER_STAGE;

    typedef struct packed {
        logic        is_div;
        logic        sgn;
        logic        w;
        logic        q_neg;
        logic        r_neg;
        logic        err;
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] dv;
        logic [15:0] result;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] flags;
    } pipe_t;

    // Sign, zero and parity from a result already masked to the operand width.
    function automatic logic [15:0] set_szp(input logic [15:0] f, input logic [15:0] r,
                                            input logic [15:0] msb);
        logic [15:0] g;
        g       = f;
        g[F_SF] = |(r & msb);
        g[F_ZF] = (r == 16'h0000);
        g[F_PF] = ~^r[7:0];
        return g;
    endfunction

    // Count modulo 17, using 16 = -1 modulo 17.
    function automatic logic [4:0] mod17(input logic [7:0] c);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = {1'b0, c[3:0]};
        hi = {1'b0, c[7:4]};
        return (lo >= hi) ? (lo - hi) : (lo + 5'd17 - hi);
    endfunction

    // Count modulo 9, using 8 = -1 and 64 = 1 modulo 9.
    function automatic logic [4:0] mod9(input logic [7:0] c);
        logic [4:0] s;
        logic [4:0] b;
        logic [4:0] t;
        s = {3'b0, c[7:6]} + {2'b0, c[2:0]};
        b = {2'b0, c[5:3]};
        if (s >= b) begin
            t = s - b;
            if (t >= 5'd9) begin
                t = t - 5'd9;
            end
        end else begin
            t = s + 5'd9 - b;
        end
        return t;
    endfunction

endpackage

FILE: rtl/x86a_front.sv
// First pipeline stage: adder, logic, shifters, rotators, multiplier and divide set-up.
// Depends on x86a_pkg.
module x86a_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [4:0]        func,
    input  logic              is_word,
    input  logic [15:0]       dest_value,
    input  logic [15:0]       source_value,
    input  logic [15:0]       ax_in,
    input  logic [15:0]       dx_in,
    input  logic [15:0]       flags_in,
    output logic              st_valid,
    output x86a_pkg::pipe_t   st
);

    logic               w;
    logic [15:0]        m16;
    logic [15:0]        msb16;
    logic [15:0]        dm;
    logic [15:0]        sm;
    logic [7:0]         cnt;
    logic               sub;
    logic [15:0]        a;
    logic [15:0]        b;
    logic [16:0]        sum17;
    logic [15:0]        r_as;
    logic [4:0]         cs;
    logic [32:0]        shl_v;
    logic               fb;
    logic [15:0]        dext;
    logic signed [32:0] ys;
    logic [3:0]         rk;
    logic [31:0]        dd;
    logic [31:0]        rl;
    logic [31:0]        rr;
    logic [15:0]        rol_r;
    logic [15:0]        ror_r;
    logic [4:0]         kc;
    logic [16:0]        z17;
    logic [8:0]         z9;
    logic [33:0]        l17;
    logic [33:0]        r17;
    logic [17:0]        l9;
    logic [17:0]        r9;
    logic [15:0]        rot_r;
    logic               rot_cf;
    logic signed [16:0] ma;
    logic signed [16:0] mb;
    logic signed [33:0] prod;
    logic               sgn;
    logic               nsign;
    logic               dsign;
    logic [31:0]        nmag;
    logic [15:0]        dmag;
    logic [15:0]        res;
    logic [15:0]        fl;
    logic [15:0]        axn;
    logic [15:0]        dxn;
    logic               hi;
    logic               cfv;
    x86a_pkg::pipe_t    nx;

    assign w     = is_word;
    assign m16   = w ? 16'hFFFF : 16'h00FF;
    assign msb16 = w ? 16'h8000 : 16'h0080;
    assign dm    = dest_value & m16;
    assign sm    = source_value & m16;
    assign cnt   = source_value[7:0];

    // Add and subtract family.
    always_comb
    begin
        sub = (func == x86a_pkg::FN_DEC) || (func == x86a_pkg::FN_SUB)
              || (func == x86a_pkg::FN_NEG);
        a   = dm;
        b   = sm;
        if ((func == x86a_pkg::FN_INC) || (func == x86a_pkg::FN_DEC)) begin
            b = 16'h0001;
        end
        if (func == x86a_pkg::FN_NEG) begin
            a = 16'h0000;
            b = dm;
        end
    end

    assign sum17 = {1'b0, a} + {1'b0, b};
    assign r_as  = (sub ? (a - b) : sum17[15:0]) & m16;

    // Shifts; counts above 17 saturate at 17.
    assign cs    = (cnt > 8'd17) ? 5'd17 : cnt[4:0];
    assign shl_v = {17'b0, dm} << cs;
    assign fb    = (func == x86a_pkg::FN_SAR) && (w ? dm[15] : dm[7]);
    assign dext  = w ? dm : {{8{fb}}, dm[7:0]};
    assign ys    = $signed({{16{fb}}, dext, 1'b0}) >>> cs;

    // Plain rotates work modulo the width.
    assign rk    = w ? cnt[3:0] : {1'b0, cnt[2:0]};
    assign dd    = w ? {dm, dm} : {16'b0, dm[7:0], dm[7:0]};
    assign rl    = dd << rk;
    assign rr    = dd >> rk;
    assign rol_r = w ? rl[31:16] : {8'b0, rl[15:8]};
    assign ror_r = w ? rr[15:0] : {8'b0, rr[7:0]};

    // Rotates through carry work modulo the width plus one.
    assign kc  = w ? x86a_pkg::mod17(cnt) : x86a_pkg::mod9(cnt);
    assign z17 = {flags_in[x86a_pkg::F_CF], dm};
    assign z9  = {flags_in[x86a_pkg::F_CF], dm[7:0]};
    assign l17 = {z17, z17} << kc;
    assign r17 = {z17, z17} >> kc;
    assign l9  = {z9, z9} << kc;
    assign r9  = {z9, z9} >> kc;

    always_comb
    begin
        rot_r  = 16'h0000;
        rot_cf = 1'b0;
        case (func)
            x86a_pkg::FN_ROL:
            begin
                rot_r  = rol_r;
                rot_cf = rol_r[0];
            end
            x86a_pkg::FN_ROR:
            begin
                rot_r  = ror_r;
                rot_cf = |(ror_r & msb16);
            end
            x86a_pkg::FN_RCL:
            begin
                rot_r  = w ? l17[32:17] : {8'b0, l9[16:9]};
                rot_cf = w ? l17[33] : l9[17];
            end
            x86a_pkg::FN_RCR:
            begin
                rot_r  = w ? r17[15:0] : {8'b0, r9[7:0]};
                rot_cf = w ? r17[16] : r9[8];
            end
            default:
            begin
                rot_r  = 16'h0000;
                rot_cf = 1'b0;
            end
        endcase
    end

    // One signed 17 by 17 multiplier serves both MUL and IMUL.
    always_comb
    begin
        if (func == x86a_pkg::FN_IMUL) begin
            ma = w ? $signed({ax_in[15], ax_in}) : $signed({{9{ax_in[7]}}, ax_in[7:0]});
            mb = w ? $signed({dm[15], dm}) : $signed({{9{dm[7]}}, dm[7:0]});
        end else begin
            ma = w ? $signed({1'b0, ax_in}) : $signed({9'b0, ax_in[7:0]});
            mb = $signed({1'b0, dm});
        end
    end

    assign prod = ma * mb;

    // Divide set-up: magnitudes of dividend and divisor and the early overflow test.
    assign sgn   = (func == x86a_pkg::FN_IDIV);
    assign nsign = sgn && (w ? dx_in[15] : ax_in[15]);
    assign dsign = sgn && (w ? dm[15] : dm[7]);
    assign nmag  = nsign ? (w ? (32'h0 - {dx_in, ax_in}) : {16'b0, 16'h0 - ax_in})
                         : (w ? {dx_in, ax_in} : {16'b0, ax_in});
    assign dmag  = dsign ? (w ? (16'h0 - dm) : {8'b0, 8'h0 - dm[7:0]}) : dm;

    always_comb
    begin
        res = dm;
        fl  = flags_in;
        axn = ax_in;
        dxn = dx_in;
        hi  = 1'b0;
        cfv = 1'b0;
        case (func)
            x86a_pkg::FN_INC, x86a_pkg::FN_DEC, x86a_pkg::FN_ADD, x86a_pkg::FN_SUB,
            x86a_pkg::FN_NEG:
            begin
                res = r_as;
                fl[x86a_pkg::F_OF] = sub ? |((a ^ b) & (a ^ r_as) & msb16)
                                         : |((a ^ r_as) & (b ^ r_as) & msb16);
                fl[x86a_pkg::F_AF] = a[4] ^ b[4] ^ r_as[4];
                if ((func != x86a_pkg::FN_INC) && (func != x86a_pkg::FN_DEC)) begin
                    fl[x86a_pkg::F_CF] = sub ? (b > a) : (w ? sum17[16] : sum17[8]);
                end
                fl = x86a_pkg::set_szp(fl, res, msb16);
            end
            x86a_pkg::FN_AND, x86a_pkg::FN_OR, x86a_pkg::FN_XOR:
            begin
                res = (func == x86a_pkg::FN_AND) ? (dm & sm)
                    : (func == x86a_pkg::FN_OR) ? (dm | sm) : (dm ^ sm);
                fl[x86a_pkg::F_CF] = 1'b0;
                fl[x86a_pkg::F_OF] = 1'b0;
                fl[x86a_pkg::F_AF] = 1'b0;
                fl = x86a_pkg::set_szp(fl, res, msb16);
            end
            x86a_pkg::FN_SHL, x86a_pkg::FN_SHR, x86a_pkg::FN_SAR:
            begin
                if (cnt != 8'd0) begin
                    if (func == x86a_pkg::FN_SHL) begin
                        res = shl_v[15:0] & m16;
                        cfv = w ? shl_v[16] : shl_v[8];
                        fl[x86a_pkg::F_OF] = (|(res & msb16)) ^ cfv;
                    end else begin
                        res = ys[16:1] & m16;
                        cfv = ys[0];
                        fl[x86a_pkg::F_OF] = (func == x86a_pkg::FN_SHR) && (|(dm & msb16));
                    end
                    fl[x86a_pkg::F_CF] = cfv;
                    fl[x86a_pkg::F_AF] = 1'b0;
                    fl = x86a_pkg::set_szp(fl, res, msb16);
                end
            end
            x86a_pkg::FN_ROL, x86a_pkg::FN_ROR, x86a_pkg::FN_RCL, x86a_pkg::FN_RCR:
            begin
                if (cnt != 8'd0) begin
                    res = rot_r;
                    fl[x86a_pkg::F_CF] = rot_cf;
                    if ((func == x86a_pkg::FN_ROL) || (func == x86a_pkg::FN_RCL)) begin
                        fl[x86a_pkg::F_OF] = (|(rot_r & msb16)) ^ rot_cf;
                    end else begin
                        fl[x86a_pkg::F_OF] = (|(rot_r & msb16)) ^ (w ? rot_r[14] : rot_r[6]);
                    end
                end
            end
            x86a_pkg::FN_MUL, x86a_pkg::FN_IMUL:
            begin
                axn = prod[15:0];
                if (w) begin
                    dxn = prod[31:16];
                    hi  = (func == x86a_pkg::FN_MUL) ? (prod[31:16] != 16'h0000)
                                                     : (prod[31:16] != {16{prod[15]}});
                end else begin
                    hi  = (func == x86a_pkg::FN_MUL) ? (prod[15:8] != 8'h00)
                                                     : (prod[15:8] != {8{prod[7]}});
                end
                fl[x86a_pkg::F_CF] = hi;
                fl[x86a_pkg::F_OF] = hi;
            end
            default:
            begin
                res = dm;
            end
        endcase
    end

    always_comb
    begin
        nx.is_div = (func == x86a_pkg::FN_DIV) || (func == x86a_pkg::FN_IDIV);
        nx.sgn    = sgn;
        nx.w      = w;
        nx.q_neg  = nsign ^ dsign;
        nx.r_neg  = nsign;
        nx.err    = nx.is_div && (nmag[31:16] >= dmag);
        nx.rem    = nmag[31:16];
        nx.quo    = nmag[15:0];
        nx.dv     = dmag;
        nx.result = res;
        nx.ax     = axn;
        nx.dx     = dxn;
        nx.flags  = fl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_valid <= 1'b0;
        end else if (advance) begin
            st_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            st <= nx;
        end
    end

endmodule

FILE: rtl/x86a_div_stage.sv
// One stage of the restoring divider, retiring a fixed number of quotient bits.
// Depends on x86a_pkg.
module x86a_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              prev_valid,
    input  x86a_pkg::pipe_t   prev,
    output logic              st_valid,
    output x86a_pkg::pipe_t   st
);

    x86a_pkg::pipe_t nx;

    // The partial remainder stays below the divisor, so the trial value fits in 17 bits.
    always_comb
    begin
        logic [16:0] t;
        nx = prev;
        for (int i = 0; i < x86a_pkg::DIV_STEPS_PER_STAGE; i++) begin
            t      = {nx.rem, nx.quo[15]};
            nx.quo = {nx.quo[14:0], 1'b0};
            if (t >= {1'b0, nx.dv}) begin
                t         = t - {1'b0, nx.dv};
                nx.quo[0] = 1'b1;
            end
            nx.rem = t[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_valid <= 1'b0;
        end else if (advance) begin
            st_valid <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            st <= nx;
        end
    end

endmodule

FILE: rtl/x86a_back.sv
// Last stage: divide sign fix-up, quotient range check and the output register.
// Depends on x86a_pkg.
module x86a_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              prev_valid,
    input  x86a_pkg::pipe_t   prev,
    output logic              out_valid,
    output logic [15:0]       result,
    output logic [15:0]       ax_out,
    output logic [15:0]       dx_out,
    output logic [15:0]       flags_out,
    output logic              divide_error
);

    logic [15:0] lim;
    logic [15:0] qs;
    logic [15:0] rs;
    logic        err;
    logic [15:0] axn;
    logic [15:0] dxn;

    assign lim = prev.sgn ? (prev.w ? 16'h7FFF : 16'h007F) : (prev.w ? 16'hFFFF : 16'h00FF);
    assign qs  = (prev.sgn && prev.q_neg) ? (16'h0 - prev.quo) : prev.quo;
    assign rs  = (prev.sgn && prev.r_neg) ? (16'h0 - prev.rem) : prev.rem;
    assign err = prev.is_div && (prev.err || (prev.quo > lim));

    always_comb
    begin
        axn = prev.ax;
        dxn = prev.dx;
        if (prev.is_div && !err) begin
            if (prev.w) begin
                axn = qs;
                dxn = rs;
            end else begin
                axn = {rs[7:0], qs[7:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end else if (advance) begin
            out_valid <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            result       <= prev.result;
            ax_out       <= axn;
            dx_out       <= dxn;
            flags_out    <= prev.flags;
            divide_error <= err;
        end
    end

endmodule

FILE: rtl/x86_16bit_alu_with_flags.sv
// Top level of the pipelined 8086 byte-or-word ALU with flags.
// Depends on x86a_pkg, x86a_front, x86a_div_stage and x86a_back.
//
//  Channel  Handshake            Payload
//  input    in_valid / in_stall  func, is_word, dest_value, source_value, ax_in, dx_in, flags_in
//  output   out_valid/ out_stall result, ax_out, dx_out, flags_out, divide_error
//
// A transaction is accepted every cycle while in_stall is low; its result passes through
// the operand stage, the divider and the output register. The divider retires two quotient
// bits per stage over eight stages between the operand stage and the output register.
// Reset clears only the valid bits of the stages; payload registers are left alone.
// The whole pipeline moves together: it holds while a finished result waits
// under out_stall, and moves otherwise, so bubbles are not squeezed out.
module x86_16bit_alu_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  func,
    input  logic        is_word,
    input  logic [15:0] dest_value,
    input  logic [15:0] source_value,
    input  logic [15:0] ax_in,
    input  logic [15:0] dx_in,
    input  logic [15:0] flags_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result,
    output logic [15:0] ax_out,
    output logic [15:0] dx_out,
    output logic [15:0] flags_out,
    output logic        divide_error
);

    logic            advance;
    logic            stv [0:x86a_pkg::DIV_STAGES];
    x86a_pkg::pipe_t stp [0:x86a_pkg::DIV_STAGES];

    // Every stage moves whenever the output register is empty or being taken.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    x86a_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .func         (func),
        .is_word      (is_word),
        .dest_value   (dest_value),
        .source_value (source_value),
        .ax_in        (ax_in),
        .dx_in        (dx_in),
        .flags_in     (flags_in),
        .st_valid     (stv[0]),
        .st           (stp[0])
    );

    for (genvar g = 0; g < x86a_pkg::DIV_STAGES; g++)
    begin : g_div
        x86a_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (stv[g]),
            .prev       (stp[g]),
            .st_valid   (stv[g + 1]),
            .st         (stp[g + 1])
        );
    end

    x86a_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .prev_valid   (stv[x86a_pkg::DIV_STAGES]),
        .prev         (stp[x86a_pkg::DIV_STAGES]),
        .out_valid    (out_valid),
        .result       (result),
        .ax_out       (ax_out),
        .dx_out       (dx_out),
        .flags_out    (flags_out),
        .divide_error (divide_error)
    );

`ifndef SYNTHESIS
    // A held pipeline must keep the divider's last stage untouched.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stp[x86a_pkg::DIV_STAGES]))
        else $error("last divider stage changed while the pipeline was held");

    // Only a divide may carry an early divide fault.
    a_err_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        stv[x86a_pkg::DIV_STAGES] && stp[x86a_pkg::DIV_STAGES].err
        |-> stp[x86a_pkg::DIV_STAGES].is_div)
        else $error("divide fault flagged on a non-divide transaction");

    // A delivered transaction drops out when taken unless a new one follows it.
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !stv[x86a_pkg::DIV_STAGES]) |=> !out_valid)
        else $error("output valid without a transaction behind it");
`endif

endmodule

FILE: tb/tb_x86_16bit_alu_with_flags.sv
// Self-checking testbench for the pipelined 8086 byte-or-word ALU with flags.
// Depends on x86a_pkg and the block x86_16bit_alu_with_flags.
`timescale 1ns / 100ps

module tb_x86_16bit_alu_with_flags;

    // One operation as seen on the input ports, and the outcome it should give.
    typedef struct {
        logic [4:0]  fn;
        logic        w;
        logic [15:0] d;
        logic [15:0] s;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] fl;
    } alu_op_t;

    typedef struct {
        logic [15:0] res;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] fl;
        logic        err;
    } alu_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [4:0]  func;
    logic        is_word;
    logic [15:0] dest_value;
    logic [15:0] source_value;
    logic [15:0] ax_in;
    logic [15:0] dx_in;
    logic [15:0] flags_in;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] result;
    logic [15:0] ax_out;
    logic [15:0] dx_out;
    logic [15:0] flags_out;
    logic        divide_error;

    // Expected outcomes, oldest first, and the running tallies.
    alu_out_t expected_q[$];
    int       mismatches;
    int       sent_count;
    int       checked_count;
    int       fault_count;

    // Idling percentages for the sender and the receiver.
    int unsigned send_gap_pct;
    int unsigned stall_pct;

    x86_16bit_alu_with_flags u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .is_word      (is_word),
        .dest_value   (dest_value),
        .source_value (source_value),
        .ax_in        (ax_in),
        .dx_in        (dx_in),
        .flags_in     (flags_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result),
        .ax_out       (ax_out),
        .dx_out       (dx_out),
        .flags_out    (flags_out),
        .divide_error (divide_error)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Sign, zero and parity of a result already cut to the operand width.
    function automatic logic [15:0] szp_flags(logic [15:0] f, logic [15:0] r, logic w);
        logic [15:0] g;
        g                = f;
        g[x86a_pkg::F_SF] = w ? r[15] : r[7];
        g[x86a_pkg::F_ZF] = (r == 16'h0000);
        g[x86a_pkg::F_PF] = ~^r[7:0];
        return g;
    endfunction

    // Works out what the ALU must give for one operation. Shifts and rotates
    // are done one step at a time, as the count is not masked.
    function automatic alu_out_t alu_predict(alu_op_t op);
        alu_out_t    o;
        logic [16:0] m;
        logic [15:0] msb;
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] r;
        logic [16:0] v;
        logic [15:0] f;
        logic [7:0]  cnt;
        logic        cf;
        logic        of;
        logic        sub;
        logic        top;
        logic        low;
        logic [31:0] p;
        logic [31:0] n;
        logic [31:0] q;
        logic [31:0] rm;
        longint      sn;
        longint      sd;
        longint      sq;
        longint      sr;
        longint      lim;
        m   = op.w ? 17'h0FFFF : 17'h000FF;
        msb = op.w ? 16'h8000 : 16'h0080;
        a   = {1'b0, op.d} & m;
        b   = {1'b0, op.s} & m;
        cnt = op.s[7:0];
        f   = op.fl;
        cf  = f[x86a_pkg::F_CF];
        of  = 1'b0;
        r   = a;
        v   = a;
        o.ax  = op.ax;
        o.dx  = op.dx;
        o.err = 1'b0;
        case (op.fn)
            x86a_pkg::FN_INC, x86a_pkg::FN_DEC, x86a_pkg::FN_ADD, x86a_pkg::FN_SUB,
            x86a_pkg::FN_NEG:
            begin
                sub = (op.fn == x86a_pkg::FN_DEC) || (op.fn == x86a_pkg::FN_SUB)
                      || (op.fn == x86a_pkg::FN_NEG);
                if (op.fn == x86a_pkg::FN_INC || op.fn == x86a_pkg::FN_DEC)
                begin
                    b = 17'd1;
                end
                if (op.fn == x86a_pkg::FN_NEG)
                begin
                    b = a;
                    a = 17'd0;
                end
                r = sub ? ((a - b) & m) : ((a + b) & m);
                if (sub)
                begin
                    of = |((a[15:0] ^ b[15:0]) & (a[15:0] ^ r[15:0]) & msb);
                end
                else
                begin
                    of = |((a[15:0] ^ r[15:0]) & (b[15:0] ^ r[15:0]) & msb);
                end
                f[x86a_pkg::F_OF] = of;
                f[x86a_pkg::F_AF] = a[4] ^ b[4] ^ r[4];
                if (op.fn != x86a_pkg::FN_INC && op.fn != x86a_pkg::FN_DEC)
                begin
                    f[x86a_pkg::F_CF] = sub ? (b > a) : ((a + b) > m);
                end
                f = szp_flags(f, r[15:0], op.w);
            end
            x86a_pkg::FN_AND, x86a_pkg::FN_OR, x86a_pkg::FN_XOR:
            begin
                r = (op.fn == x86a_pkg::FN_AND) ? (a & b)
                  : (op.fn == x86a_pkg::FN_OR) ? (a | b) : (a ^ b);
                f[x86a_pkg::F_CF] = 1'b0;
                f[x86a_pkg::F_OF] = 1'b0;
                f[x86a_pkg::F_AF] = 1'b0;
                f = szp_flags(f, r[15:0], op.w);
            end
            x86a_pkg::FN_SHL, x86a_pkg::FN_SHR, x86a_pkg::FN_SAR:
            begin
                if (cnt != 0)
                begin
                    of = (op.fn == x86a_pkg::FN_SHR) && |(a[15:0] & msb);
                    for (int i = 0; i < cnt; i++)
                    begin
                        if (op.fn == x86a_pkg::FN_SHL)
                        begin
                            cf = |(v[15:0] & msb);
                            v  = (v << 1) & m;
                        end
                        else
                        begin
                            cf = v[0];
                            v  = (v >> 1) | ((op.fn == x86a_pkg::FN_SAR) ? (v & {1'b0, msb})
                                                                         : 17'd0);
                        end
                    end
                    r = v;
                    if (op.fn == x86a_pkg::FN_SHL)
                    begin
                        of = |(r[15:0] & msb) ^ cf;
                    end
                    f[x86a_pkg::F_CF] = cf;
                    f[x86a_pkg::F_OF] = of;
                    f[x86a_pkg::F_AF] = 1'b0;
                    f = szp_flags(f, r[15:0], op.w);
                end
            end
            x86a_pkg::FN_ROL, x86a_pkg::FN_ROR, x86a_pkg::FN_RCL, x86a_pkg::FN_RCR:
            begin
                if (cnt != 0)
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        top = |(v[15:0] & msb);
                        low = v[0];
                        case (op.fn)
                            x86a_pkg::FN_ROL:
                            begin
                                v  = ((v << 1) & m) | {16'b0, top};
                                cf = top;
                            end
                            x86a_pkg::FN_ROR:
                            begin
                                v  = (v >> 1) | (low ? {1'b0, msb} : 17'd0);
                                cf = low;
                            end
                            x86a_pkg::FN_RCL:
                            begin
                                v  = ((v << 1) & m) | {16'b0, cf};
                                cf = top;
                            end
                            default:
                            begin
                                v  = (v >> 1) | (cf ? {1'b0, msb} : 17'd0);
                                cf = low;
                            end
                        endcase
                    end
                    r = v;
                    if (op.fn == x86a_pkg::FN_ROL || op.fn == x86a_pkg::FN_RCL)
                    begin
                        of = |(r[15:0] & msb) ^ cf;
                    end
                    else
                    begin
                        of = |(r[15:0] & msb) ^ |(r[15:0] & (msb >> 1));
                    end
                    f[x86a_pkg::F_CF] = cf;
                    f[x86a_pkg::F_OF] = of;
                end
            end
            x86a_pkg::FN_MUL, x86a_pkg::FN_IMUL:
            begin
                if (op.w)
                begin
                    if (op.fn == x86a_pkg::FN_MUL)
                    begin
                        p = op.ax * op.d;
                    end
                    else
                    begin
                        p = $signed(op.ax) * $signed(op.d);
                    end
                    o.ax = p[15:0];
                    o.dx = p[31:16];
                    of = (op.fn == x86a_pkg::FN_MUL) ? (p[31:16] != 16'h0000)
                                                     : (p[31:16] != {16{p[15]}});
                end
                else
                begin
                    if (op.fn == x86a_pkg::FN_MUL)
                    begin
                        p = op.ax[7:0] * op.d[7:0];
                    end
                    else
                    begin
                        p = $signed(op.ax[7:0]) * $signed(op.d[7:0]);
                    end
                    o.ax = p[15:0];
                    of = (op.fn == x86a_pkg::FN_MUL) ? (p[15:8] != 8'h00)
                                                     : (p[15:8] != {8{p[7]}});
                end
                f[x86a_pkg::F_CF] = of;
                f[x86a_pkg::F_OF] = of;
            end
            x86a_pkg::FN_DIV, x86a_pkg::FN_IDIV:
            begin
                if (a == 0)
                begin
                    o.err = 1'b1;
                end
                else if (op.fn == x86a_pkg::FN_DIV)
                begin
                    n  = op.w ? {op.dx, op.ax} : {16'h0, op.ax};
                    q  = n / a;
                    rm = n % a;
                    if (q > m)
                    begin
                        o.err = 1'b1;
                    end
                    else if (op.w)
                    begin
                        o.ax = q[15:0];
                        o.dx = rm[15:0];
                    end
                    else
                    begin
                        o.ax = {rm[7:0], q[7:0]};
                    end
                end
                else
                begin
                    sn  = op.w ? longint'($signed({op.dx, op.ax})) : longint'($signed(op.ax));
                    sd  = op.w ? longint'($signed(a[15:0])) : longint'($signed(a[7:0]));
                    sq  = sn / sd;
                    sr  = sn % sd;
                    lim = op.w ? 64'sd32767 : 64'sd127;
                    if (sq > lim || sq < -lim)
                    begin
                        o.err = 1'b1;
                    end
                    else if (op.w)
                    begin
                        o.ax = sq[15:0];
                        o.dx = sr[15:0];
                    end
                    else
                    begin
                        o.ax = {sr[7:0], sq[7:0]};
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.res = r[15:0] & m[15:0];
        o.fl  = f;
        return o;
    endfunction

    // Sends one operation: its outcome is queued, it is driven at the falling
    // edge after an optional random gap, and held until the block takes it.
    task automatic send_op(alu_op_t op);
        while (($urandom % 100) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        expected_q.push_back(alu_predict(op));
        if (op.fn == x86a_pkg::FN_DIV || op.fn == x86a_pkg::FN_IDIV)
        begin
            if (expected_q[$].err)
            begin
                fault_count++;
            end
        end
        in_valid     <= 1'b1;
        func         <= op.fn;
        is_word      <= op.w;
        dest_value   <= op.d;
        source_value <= op.s;
        ax_in        <= op.ax;
        dx_in        <= op.dx;
        flags_in     <= op.fl;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every queued outcome has been checked or the guard runs out.
    task automatic drain;
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    function automatic alu_op_t make_op(logic [4:0] fn, logic w, logic [15:0] d,
                                        logic [15:0] s, logic [15:0] ax,
                                        logic [15:0] dx, logic [15:0] fl);
        alu_op_t op;
        op.fn = fn;
        op.w  = w;
        op.d  = d;
        op.s  = s;
        op.ax = ax;
        op.dx = dx;
        op.fl = fl;
        return op;
    endfunction

    // A random operation. Counts favour the small and the interesting ones, and
    // divides are often built to stay in range so that real quotients come out.
    function automatic alu_op_t random_op();
        alu_op_t     op;
        logic [15:0] q;
        op.fn = 5'($urandom_range(0, 18));
        op.w  = 1'($urandom_range(0, 1));
        op.d  = 16'($urandom);
        op.s  = 16'($urandom);
        op.ax = 16'($urandom);
        op.dx = 16'($urandom);
        op.fl = 16'($urandom);
        if (op.fn >= x86a_pkg::FN_SHL && op.fn != x86a_pkg::FN_NEG
            && op.fn <= x86a_pkg::FN_RCR)
        begin
            case ($urandom_range(0, 3))
                0: op.s[7:0] = 8'($urandom_range(0, 3));
                1: op.s[7:0] = 8'($urandom_range(4, 18));
                default: ;
            endcase
        end
        if ((op.fn == x86a_pkg::FN_DIV || op.fn == x86a_pkg::FN_IDIV)
            && $urandom_range(0, 3) != 0)
        begin
            // Keep the high part of the dividend below the divisor.
            if (op.w)
            begin
                op.dx = (op.fn == x86a_pkg::FN_DIV) ? (op.dx % (op.d | 16'h0001))
                                                    : {{9{op.dx[15]}}, op.dx[6:0]};
                if (op.d == 0) op.d = 16'h0001;
                if (op.fn == x86a_pkg::FN_IDIV) op.d[14:8] = {7{~op.d[15]}};
            end
            else
            begin
                if (op.d[7:0] == 0) op.d[7:0] = 8'h03;
                q = op.ax;
                op.ax[15:8] = (op.fn == x86a_pkg::FN_DIV) ? (q[15:8] % op.d[7:0])
                                                          : {{5{q[15]}}, q[10:8]};
                if (op.fn == x86a_pkg::FN_IDIV) op.d[6:4] = {3{~op.d[7]}};
            end
        end
        return op;
    endfunction

    // Each operation at its extremes, in one width or both.
    task automatic test_directed_extremes;
        send_op(make_op(x86a_pkg::FN_INC,  1'b1, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_DEC,  1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF));
        send_op(make_op(x86a_pkg::FN_ADD,  1'b1, 16'hFFFF, 16'h0001, 16'h1234, 16'h5678,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_ADD,  1'b0, 16'hAA7F, 16'h5501, 16'h0000, 16'h0000,
                        16'hFFFE));
        send_op(make_op(x86a_pkg::FN_SUB,  1'b1, 16'h8000, 16'h0001, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_SUB,  1'b0, 16'h0000, 16'h00FF, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_AND,  1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                        16'hFFFF));
        send_op(make_op(x86a_pkg::FN_OR,   1'b0, 16'hFF80, 16'h0001, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_XOR,  1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                        16'h0801));
        send_op(make_op(x86a_pkg::FN_NEG,  1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_NEG,  1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000));
        // Shift and rotate by zero leave everything alone; large counts run out.
        send_op(make_op(x86a_pkg::FN_SHL,  1'b1, 16'h8001, 16'hFF00, 16'h0000, 16'h0000,
                        16'hFFFF));
        send_op(make_op(x86a_pkg::FN_SHL,  1'b0, 16'h00C1, 16'h0001, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_SHR,  1'b1, 16'h8001, 16'h00FF, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_SAR,  1'b0, 16'h0080, 16'h0009, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_ROL,  1'b1, 16'h8000, 16'h0011, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_ROR,  1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
                        16'h0801));
        send_op(make_op(x86a_pkg::FN_RCL,  1'b0, 16'h0080, 16'h0009, 16'h0000, 16'h0000,
                        16'h0001));
        send_op(make_op(x86a_pkg::FN_RCR,  1'b1, 16'h0001, 16'h0011, 16'h0000, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_MUL,  1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_IMUL, 1'b0, 16'h0080, 16'h0000, 16'h0080, 16'h0000,
                        16'h0000));
        // Divide by zero, quotient overflow, the signed limit and a clean divide.
        send_op(make_op(x86a_pkg::FN_DIV,  1'b1, 16'h0000, 16'h0000, 16'h1234, 16'h0001,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_DIV,  1'b0, 16'h0001, 16'h0000, 16'h0100, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_IDIV, 1'b0, 16'h00FF, 16'h0000, 16'h0080, 16'h0000,
                        16'h0000));
        send_op(make_op(x86a_pkg::FN_IDIV, 1'b1, 16'hFFFD, 16'h0000, 16'hFFF9, 16'hFFFF,
                        16'h0000));
        drain();
    endtask

    // Random operations under one idling pattern.
    task automatic test_random_phase(int count, int unsigned gap, int unsigned stall);
        send_gap_pct = gap;
        stall_pct    = stall;
        for (int i = 0; i < count; i++)
        begin
            send_op(random_op());
        end
        drain();
    endtask

    // Receiver: stall is changed at the falling edge, results are taken at the
    // rising edge when valid is high and stall is low.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= (($urandom % 100) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                want = expected_q.pop_front();
                checked_count++;
                if (result !== want.res || ax_out !== want.ax || dx_out !== want.dx ||
                    flags_out !== want.fl || divide_error !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: transaction %0d: expected res %h ax %h dx %h fl %h err %b",
                                 checked_count, want.res, want.ax, want.dx, want.fl,
                                 want.err);
                        $display("       got res %h ax %h dx %h fl %h err %b",
                                 result, ax_out, dx_out, flags_out, divide_error);
                    end
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timeout after %0d transactions checked", checked_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        func         = x86a_pkg::FN_INC;
        is_word      = 1'b0;
        dest_value   = 16'h0;
        source_value = 16'h0;
        ax_in        = 16'h0;
        dx_in        = 16'h0;
        flags_in     = 16'h0;
        mismatches   = 0;
        sent_count   = 0;
        checked_count = 0;
        fault_count  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_random_phase(110, 0, 0);
        test_random_phase(110, 65, 0);
        test_random_phase(110, 0, 65);
        test_random_phase(110, 24, 24);

        // Allow for the pipeline depth, then make sure nothing stray turns up.
        stall_pct = 0;
        repeat (30) @(negedge clk);
        if (expected_q.size() != 0)
            mismatches++;

        $display("Checked %0d of %0d transactions over all operations, both widths,",
                 checked_count, sent_count);
        $display("four idling patterns; %0d divides faulted, %0d mismatches.",
                 fault_count, mismatches);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/x86a_pkg.sv
rtl/x86a_front.sv
rtl/x86a_div_stage.sv
rtl/x86a_back.sv
rtl/x86_16bit_alu_with_flags.sv
tb/tb_x86_16bit_alu_with_flags.sv
